@@ design/bgl_pkg.sv @@
package bgl_pkg;

  // Glyph table depth and the widths that follow from it
  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned CMP_W       = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CELL_W  = 12;
  localparam int unsigned GIDX_W  = 7;
  localparam int unsigned DIV_CNT_W = $clog2(GIDX_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_HEIGHT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GLYPHS_PER_ROW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN      = CFG_IDX_W'(3);

  // Operation codes
  localparam logic OP_LOCATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [CODE_W-1:0]         char_code;
    logic [SLOT_W-1:0]         table_slot;
    logic [POS_W-1:0]          text_position;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]        src_x;
    logic [COORD_W-1:0]        src_y;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic [GIDX_W-1:0]         glyph_index;
    logic                      found;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // Search wave passed from cell to cell
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [GIDX_W-1:0] idx;
    logic [CODE_W-1:0] code;
  } wave_t;

  // Table write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
  } table_wr_t;

  // Divider control
  typedef struct packed {
    logic              start;
    logic [GIDX_W-1:0] dividend;
    logic [GIDX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GIDX_W-1:0] quot;
    logic [GIDX_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ design/bgl_if.sv @@
interface bgl_in_if;
  logic               valid;
  logic               ready;
  bgl_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bgl_out_if;
  logic               valid;
  logic               ready;
  bgl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bgl_cfg_if;
  logic               valid;
  logic               ready;
  bgl_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bgl_cell.sv @@
module bgl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bgl_pkg::IDX_W-1:0]   cell_idx_i,
  input  logic [bgl_pkg::GIDX_W-1:0]  table_len_i,
  input  bgl_pkg::table_wr_t          wr_i,
  input  bgl_pkg::wave_t              wave_i,
  output bgl_pkg::wave_t              wave_o
);

  logic [bgl_pkg::CODE_W-1:0] entry_q;
  logic                       sel_wr;
  logic                       in_range;
  logic                       match;
  bgl_pkg::wave_t             wave_d;
  bgl_pkg::wave_t             wave_q;

  assign sel_wr   = wr_i.en &&
                    (bgl_pkg::CMP_W'(wr_i.slot) == bgl_pkg::CMP_W'(cell_idx_i));
  assign in_range = bgl_pkg::CMP_W'(cell_idx_i) < bgl_pkg::CMP_W'(table_len_i);
  assign match    = wave_i.active && in_range && (entry_q == wave_i.code);

  // Table entry held by this cell
  always_ff @(posedge clk_i) begin
    if (sel_wr) begin
      entry_q <= wr_i.code;
    end
  end

  // First match wins; later cells only pass the wave along
  always_comb begin
    wave_d     = wave_i;
    wave_d.hit = wave_i.hit | match;
    if (!wave_i.hit && match) begin
      wave_d.idx = bgl_pkg::GIDX_W'(cell_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

@@ design/bgl_div.sv @@
module bgl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgl_pkg::div_req_t  req_i,
  output bgl_pkg::div_rsp_t  rsp_o
);

  logic                              busy_q, busy_d;
  logic [bgl_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [bgl_pkg::GIDX_W-1:0]        rem_q, rem_d;
  logic [bgl_pkg::GIDX_W-1:0]        quo_q, quo_d;
  logic [bgl_pkg::GIDX_W-1:0]        div_q, div_d;
  logic [bgl_pkg::GIDX_W:0]          rem_sh;
  logic                              ge;

  // One restoring step per cycle, dividend shifted in through quo_q
  assign rem_sh = {rem_q, quo_q[bgl_pkg::GIDX_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = bgl_pkg::DIV_CNT_W'(bgl_pkg::GIDX_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? bgl_pkg::GIDX_W'(rem_sh - {1'b0, div_q})
                 : rem_sh[bgl_pkg::GIDX_W-1:0];
      quo_d = {quo_q[bgl_pkg::GIDX_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  // Done is seen the cycle after the last step
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0) && !req_i.start;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ design/bitmap_glyph_locator_unit.sv @@
// Glyph locator: load transactions (operation 1) store a character code into one
// glyph table entry when taken and give no result; every 7-bit slot names an
// entry. A locate transaction (operation 0) sends a search wave down a chain of
// bgl_pkg::TABLE_DEPTH cells, one cell per cycle, to find the first entry below
// table_len that holds the code (no match gives index table_len, found 0). A
// restoring divider then splits the index by glyphs_per_row (0 acts as 1),
// and a multiply and a saturate stage form the source corner and the destination.
// A locate's steps, in order: the wave leaves the cell chain, then come the
// divider start, seven divider steps, its done flag, the multiply and the
// saturate step. Input is taken again once the sequencer is back in idle after
// the saturate step; input is taken only while no locate is in flight. A finished
// result waits in an output register, so the next transaction can be taken
// meanwhile; while that register is still full, a following locate waits in its
// saturate step.
// Configuration writes are taken every cycle and should be made while idle.
module bitmap_glyph_locator_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  bgl_cfg_if.sink   cfg_i,
  bgl_in_if.sink    in_i,
  bgl_out_if.source res_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_DIV    = 5'b00100,
    S_MUL    = 5'b01000,
    S_SAT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [bgl_pkg::CELL_W-1:0] char_width_q;
  logic [bgl_pkg::CELL_W-1:0] char_height_q;
  logic [bgl_pkg::GIDX_W-1:0] glyphs_per_row_q;
  logic [bgl_pkg::GIDX_W-1:0] table_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_width_q     <= bgl_pkg::CELL_W'(8);
      char_height_q    <= bgl_pkg::CELL_W'(8);
      glyphs_per_row_q <= bgl_pkg::GIDX_W'(16);
      table_len_q      <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        bgl_pkg::REG_CHAR_WIDTH: begin
          char_width_q <= cfg_i.data.data[bgl_pkg::CELL_W-1:0];
        end
        bgl_pkg::REG_CHAR_HEIGHT: begin
          char_height_q <= cfg_i.data.data[bgl_pkg::CELL_W-1:0];
        end
        bgl_pkg::REG_GLYPHS_PER_ROW: begin
          glyphs_per_row_q <= cfg_i.data.data[bgl_pkg::GIDX_W-1:0];
        end
        bgl_pkg::REG_TABLE_LEN: begin
          table_len_q <= cfg_i.data.data[bgl_pkg::GIDX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input handshake
  logic in_fire;
  logic locate_start;

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign locate_start = in_fire && (in_i.data.operation == bgl_pkg::OP_LOCATE);

  // Locate transaction payload
  logic [bgl_pkg::POS_W-1:0]          pos_q;
  logic signed [bgl_pkg::COORD_W-1:0] ox_q;
  logic signed [bgl_pkg::COORD_W-1:0] oy_q;

  always_ff @(posedge clk_i) begin
    if (locate_start) begin
      pos_q <= in_i.data.text_position;
      ox_q  <= in_i.data.origin_x;
      oy_q  <= in_i.data.origin_y;
    end
  end

  // Cell chain
  bgl_pkg::table_wr_t wr;
  bgl_pkg::wave_t     wave [bgl_pkg::TABLE_DEPTH+1];

  assign wr.en   = in_fire && (in_i.data.operation == bgl_pkg::OP_LOAD);
  assign wr.slot = in_i.data.table_slot;
  assign wr.code = in_i.data.char_code;

  assign wave[0].active = locate_start;
  assign wave[0].hit    = 1'b0;
  assign wave[0].idx    = '0;
  assign wave[0].code   = in_i.data.char_code;

  for (genvar k = 0; k < bgl_pkg::TABLE_DEPTH; k++) begin : g_cell
    bgl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (bgl_pkg::IDX_W'(k)),
      .table_len_i (table_len_q),
      .wr_i        (wr),
      .wave_i      (wave[k]),
      .wave_o      (wave[k+1])
    );
  end

  bgl_pkg::wave_t wave_end;
  assign wave_end = wave[bgl_pkg::TABLE_DEPTH];

  // Search result
  logic [bgl_pkg::GIDX_W-1:0] idx_q;
  logic                       hit_q;
  logic [bgl_pkg::GIDX_W-1:0] idx_sel;

  assign idx_sel = wave_end.hit ? wave_end.idx : table_len_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEARCH && wave_end.active) begin
      idx_q <= idx_sel;
      hit_q <= wave_end.hit;
    end
  end

  // Column and row split
  bgl_pkg::div_req_t div_req;
  bgl_pkg::div_rsp_t div_rsp;

  assign div_req.start    = (state_q == S_SEARCH) && wave_end.active;
  assign div_req.dividend = idx_sel;
  assign div_req.divisor  = (glyphs_per_row_q == '0) ? bgl_pkg::GIDX_W'(1)
                                                       : glyphs_per_row_q;

  bgl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Products, registered before the saturation stage
  localparam int unsigned SRC_P_W = bgl_pkg::GIDX_W + bgl_pkg::CELL_W;
  localparam int unsigned DST_P_W = bgl_pkg::POS_W + bgl_pkg::CELL_W;
  localparam int unsigned SUM_W   = DST_P_W + 2;

  logic [SRC_P_W-1:0] src_x_p_q;
  logic [SRC_P_W-1:0] src_y_p_q;
  logic [DST_P_W-1:0] dst_p_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      src_x_p_q <= SRC_P_W'(div_rsp.rem) * SRC_P_W'(char_width_q);
      src_y_p_q <= SRC_P_W'(div_rsp.quot) * SRC_P_W'(char_height_q);
      dst_p_q   <= DST_P_W'(pos_q) * DST_P_W'(char_width_q);
    end
  end

  // Saturation
  logic signed [SUM_W-1:0]            dst_sum;
  logic [bgl_pkg::COORD_W-1:0]        src_x_sat;
  logic [bgl_pkg::COORD_W-1:0]        src_y_sat;
  logic signed [bgl_pkg::COORD_W-1:0] dst_x_sat;

  assign dst_sum   = SUM_W'(ox_q) + signed'({2'b00, dst_p_q});
  assign src_x_sat = (|src_x_p_q[SRC_P_W-1:bgl_pkg::COORD_W]) ? '1
                                                             : src_x_p_q[bgl_pkg::COORD_W-1:0];
  assign src_y_sat = (|src_y_p_q[SRC_P_W-1:bgl_pkg::COORD_W]) ? '1
                                                             : src_y_p_q[bgl_pkg::COORD_W-1:0];
  // The sum never goes below the 16-bit minimum since the product is not negative
  assign dst_x_sat = (!dst_sum[SUM_W-1] && (|dst_sum[SUM_W-2:bgl_pkg::COORD_W-1]))
                     ? {1'b0, {(bgl_pkg::COORD_W-1){1'b1}}}
                     : dst_sum[bgl_pkg::COORD_W-1:0];

  // Output register
  logic               out_valid_q;
  bgl_pkg::out_item_t out_data_q;
  logic               out_load;

  assign out_load = (state_q == S_SAT) && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.src_x       <= src_x_sat;
      out_data_q.src_y       <= src_y_sat;
      out_data_q.dst_x       <= dst_x_sat;
      out_data_q.dst_y       <= oy_q;
      out_data_q.glyph_index <= idx_q;
      out_data_q.found       <= hit_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (locate_start) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (wave_end.active) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
